### src/ddrc_pkg.sv
`timescale 1ns / 1ps

package ddrc_pkg;

    localparam int VALUE_W     = 31;
    localparam int BCD_W       = 40;
    localparam int BCD_NIBBLES = BCD_W / 4;
    localparam int COUNT_OUT_W = 4;
    localparam int RADIX       = 10;
    // covers a digit count up to 31
    localparam int COUNT_W     = 5;
    localparam int DEF_MAX_DIGITS = 10;

    // ceil(2^35 / 10): exact quotient of any 32-bit value by ten after >> 35
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int          RECIP_SH  = 35;
    localparam int          QUOT_W    = 28;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [BCD_W-1:0]   bcd;
        logic [COUNT_W-1:0] count;
        logic [RADIX-1:0]   seen;
        logic               repeated;
    } t_dd_data;

endpackage

### src/decimal_digits_with_repeat_check.sv
`timescale 1ns / 1ps

// binary to bcd converter with a repeated-digit flag
// input channel: i_valid / o_ready carry one unsigned value per item on i_value
// output channel: o_valid / i_ready carry o_bcd_digits (least significant digit
// in bits 3:0, unused nibbles zero), o_digit_count (zero counts as one digit)
// and o_has_repeat (some digit value occurs twice among the kept digits)
// the converter is a row of MAX_DIGITS cells; each cell takes off one digit
// with a reciprocal multiply by ten and hands the quotient to the next cell
// every cell registers its result before handing it on
// throughput: one item per cycle while i_ready stays high, set by one multiply per cell per cycle
// every cell has its own valid and ready, so a stalled receiver holds the
// result in the last cell while earlier cells keep taking items until the
// row is full; o_ready falls only when every cell holds an item
// if MAX_DIGITS is below the number of digits, only the low digits are kept
// reset (synchronous, active low) drops all items in flight; the block keeps
// no other state

module decimal_digits_with_repeat_check #(
    parameter int MAX_DIGITS = ddrc_pkg::DEF_MAX_DIGITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ddrc_pkg::VALUE_W-1:0]      i_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ddrc_pkg::BCD_W-1:0]        o_bcd_digits,
    output logic [ddrc_pkg::COUNT_OUT_W-1:0]  o_digit_count,
    output logic                              o_has_repeat
);
    import ddrc_pkg::*;

    logic     w_valid [MAX_DIGITS+1];
    logic     w_ready [MAX_DIGITS+1];
    t_dd_data w_data  [MAX_DIGITS+1];

    always_comb begin
        w_data[0]          = '0;
        w_data[0].value    = i_value;
    end
    assign w_valid[0] = i_valid;
    assign o_ready    = w_ready[0];

    genvar g;
    generate
        for (g = 0; g < MAX_DIGITS; g++) begin : g_cell
            ddrc_cell #(
                .DIGIT_IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[g]),
                .o_ready (w_ready[g]),
                .i_data  (w_data[g]),
                .o_valid (w_valid[g+1]),
                .i_ready (w_ready[g+1]),
                .o_data  (w_data[g+1])
            );
        end
    endgenerate

    assign w_ready[MAX_DIGITS] = i_ready;
    assign o_valid       = w_valid[MAX_DIGITS];
    assign o_bcd_digits  = w_data[MAX_DIGITS].bcd;
    assign o_digit_count = w_data[MAX_DIGITS].count[COUNT_OUT_W-1:0];
    assign o_has_repeat  = w_data[MAX_DIGITS].repeated;

    // the row only refuses an item when the receiver holds back a result
    a_full_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input refused without an output stall");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (w_data[MAX_DIGITS].count != '0))
        else $error("result with no digits");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (w_data[MAX_DIGITS].count <= COUNT_W'(MAX_DIGITS)))
        else $error("digit count above slot count");

    a_single_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_digit_count == COUNT_OUT_W'(1))) |->
            (!o_has_repeat && (o_bcd_digits[BCD_W-1:4] == '0)))
        else $error("single digit result with upper nibbles or repeat set");

endmodule

### src/ddrc_cell.sv
`timescale 1ns / 1ps

module ddrc_cell #(
    parameter int DIGIT_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ddrc_pkg::t_dd_data i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output ddrc_pkg::t_dd_data o_data
);
    import ddrc_pkg::*;

    logic        r_valid;
    t_dd_data    r_data;
    t_dd_data    n_data;
    logic [31:0] w_n32;
    logic [63:0] w_prod;
    logic [QUOT_W-1:0]  w_quot;
    logic [VALUE_W-1:0] w_quot10;
    logic [VALUE_W-1:0] w_rem;
    logic [3:0]  w_digit;
    logic        w_active;
    logic [BCD_W-1:0]   w_bcd;

    // divide by ten through the reciprocal, remainder by shift-add
    assign w_n32    = {1'b0, i_data.value};
    assign w_prod   = w_n32 * RECIP_TEN;
    assign w_quot   = w_prod[RECIP_SH +: QUOT_W];
    assign w_quot10 = {w_quot, 3'b000} + {2'b00, w_quot, 1'b0};
    assign w_rem    = i_data.value - w_quot10;
    assign w_digit  = w_rem[3:0];

    // a cell past the first only works while something is left
    assign w_active = (DIGIT_IDX == 0) || (i_data.value != '0);

    generate
        if (DIGIT_IDX < BCD_NIBBLES) begin : g_nibble
            always_comb begin
                w_bcd = i_data.bcd;
                w_bcd[4*DIGIT_IDX +: 4] = w_digit;
            end
        end else begin : g_no_nibble
            assign w_bcd = i_data.bcd;
        end
    endgenerate

    always_comb begin
        n_data = i_data;
        if (w_active) begin
            n_data.value    = {{(VALUE_W-QUOT_W){1'b0}}, w_quot};
            n_data.bcd      = w_bcd;
            n_data.count    = i_data.count + COUNT_W'(1);
            n_data.seen     = i_data.seen | (RADIX'(1) << w_digit);
            n_data.repeated = i_data.repeated | i_data.seen[w_digit];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### sim/tb_decimal_digits_with_repeat_check.sv
`timescale 1ns / 1ps

module tb_decimal_digits_with_repeat_check;
    import ddrc_pkg::*;

    localparam int DIGIT_SLOTS  = DEF_MAX_DIGITS;
    localparam int VALUE_TOP    = 2147483647;
    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 4 * DIGIT_SLOTS;

    typedef struct packed {
        logic [BCD_W-1:0]       bcd;
        logic [COUNT_OUT_W-1:0] count;
        logic                   repeated;
    } t_digit_result;

    class t_digit_ledger;
        t_digit_result pending[$];
        int            failures;

        function new();
            failures = 0;
        endfunction

        // repeated division by ten, one digit slot at a time
        function t_digit_result split_decimal(logic [VALUE_W-1:0] value);
            t_digit_result res;
            logic [31:0]   n;
            logic [3:0]    digit;
            logic [9:0]    seen;
            res  = '0;
            seen = '0;
            n    = {1'b0, value};
            for (int d = 0; d < DIGIT_SLOTS; d++) begin
                if (n == 0 && d > 0) break;
                digit = 4'(n % 10);
                n     = n / 10;
                if (d < BCD_NIBBLES) res.bcd[4*d +: 4] = digit;
                if (seen[digit]) res.repeated = 1'b1;
                seen[digit] = 1'b1;
                res.count   = res.count + 1'b1;
            end
            return res;
        endfunction

        function void note_value(logic [VALUE_W-1:0] value);
            pending.push_back(split_decimal(value));
        endfunction

        function void check_digits(logic [BCD_W-1:0] bcd, logic [COUNT_OUT_W-1:0] count,
                                   logic repeated);
            t_digit_result want;
            if (pending.size() == 0) begin
                $error("result with no item outstanding: bcd_digits %h", bcd);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (bcd !== want.bcd) begin
                $error("bcd_digits expected %h actual %h", want.bcd, bcd);
                failures++;
            end
            if (count !== want.count) begin
                $error("digit_count expected %0d actual %0d", want.count, count);
                failures++;
            end
            if (repeated !== want.repeated) begin
                $error("has_repeat expected %b actual %b", want.repeated, repeated);
                failures++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [VALUE_W-1:0]     i_value;
    logic                   o_valid;
    logic                   i_ready;
    logic [BCD_W-1:0]       o_bcd_digits;
    logic [COUNT_OUT_W-1:0] o_digit_count;
    logic                   o_has_repeat;

    t_digit_ledger ledger = new();
    int            values_taken;
    int            cycle_count;
    bit            steady_flow;
    bit            stimulus_done;

    decimal_digits_with_repeat_check #(
        .MAX_DIGITS(DIGIT_SLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_bcd_digits (o_bcd_digits),
        .o_digit_count(o_digit_count),
        .o_has_repeat (o_has_repeat)
    );

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    // both handshakes seen with pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                ledger.note_value(i_value);
                values_taken++;
            end
            if (o_valid && i_ready) begin
                ledger.check_digits(o_bcd_digits, o_digit_count, o_has_repeat);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // valid stays high across back-to-back items, dropped only for a gap
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic [VALUE_W-1:0] value_of_length(int len);
        longint lo;
        longint hi;
        lo = 1;
        for (int k = 1; k < len; k++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (len == 1) lo = 0;
        if (hi > VALUE_TOP) hi = VALUE_TOP;
        return VALUE_W'($urandom_range(32'(hi), 32'(lo)));
    endfunction

    // shuffled digits, so no digit occurs twice
    function automatic logic [VALUE_W-1:0] distinct_value(int len);
        int     digits[10];
        int     j;
        int     t;
        longint acc;
        for (int k = 0; k < 10; k++) digits[k] = k;
        for (int k = 9; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = digits[k];
            digits[k] = digits[j];
            digits[j] = t;
        end
        if (len == 10) begin
            for (int k = 0; k < 10; k++) begin
                if (digits[k] == 1) begin
                    digits[k] = digits[0];
                    digits[0] = 1;
                end
            end
        end else if (len > 1 && digits[0] == 0) begin
            digits[0] = digits[len-1];
            digits[len-1] = 0;
        end
        acc = 0;
        for (int k = 0; k < len; k++) acc = acc * 10 + digits[k];
        return VALUE_W'(acc);
    endfunction

    function automatic logic [VALUE_W-1:0] patterned_value();
        int     len;
        int     digit;
        longint acc;
        longint pow;
        len = $urandom_range(1, 9);
        case ($urandom_range(0, 2))
            0: begin
                digit = $urandom_range(1, 9);
                acc = 0;
                for (int k = 0; k < len; k++) acc = acc * 10 + digit;
            end
            1: begin
                pow = 1;
                for (int k = 0; k < len; k++) pow = pow * 10;
                acc = pow + $urandom_range(0, 2) - 1;
            end
            default: begin
                acc = longint'($urandom_range(0, 15)) << $urandom_range(0, 27);
            end
        endcase
        return VALUE_W'(acc);
    endfunction

    // receiver: short and long stalls, quiet stretches and two long hold-offs
    initial begin
        int hold_cycles;
        int holds_done;
        int r;
        hold_cycles = 0;
        holds_done  = 0;
        i_ready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready <= 1'b0;
            end else if ((holds_done == 0 && values_taken >= 300) ||
                         (holds_done == 1 && values_taken >= 1300)) begin
                holds_done++;
                hold_cycles = 120;
                i_ready <= 1'b0;
            end else if (steady_flow || stimulus_done) begin
                i_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    i_ready <= 1'b0;
                    hold_cycles = (r < 2) ? $urandom_range(8, 25) : $urandom_range(0, 2);
                end else begin
                    i_ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("decimal_digits_with_repeat_check regression: fail");
        $finish;
    end

    initial begin
        logic [VALUE_W-1:0] corner_values[$];
        int                 r;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_value       = '0;
        values_taken  = 0;
        steady_flow   = 1'b0;
        stimulus_done = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero, single digits, digit-count boundaries, all-ones and lone high bit
        corner_values = '{0, 1, 9, 10, 11, 99, 100, 101, 999999999, 1000000000,
                          1023456789, 1234567890, 1987654320, 2147483647, 2147483646,
                          1073741824, 1111111111, 2000000000, 123456789, 9876543,
                          1000000001, 1999999999, 55};
        foreach (corner_values[k]) send_value(corner_values[k]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_flow = (n >= 600 && n < 800);
            r = $urandom_range(0, 99);
            if (r < 40) send_value(value_of_length($urandom_range(1, 10)));
            else if (r < 65) send_value(VALUE_W'($urandom));
            else if (r < 90) send_value(distinct_value($urandom_range(1, 10)));
            else send_value(patterned_value());
        end
        i_valid       <= 1'b0;
        stimulus_done  = 1'b1;
        steady_flow    = 1'b0;

        while (ledger.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (ledger.pending.size() != 0) begin
            $error("%0d results never arrived", ledger.pending.size());
            ledger.failures++;
        end
        if (ledger.failures == 0) begin
            $display("decimal_digits_with_repeat_check regression: pass");
        end else begin
            $display("decimal_digits_with_repeat_check regression: fail");
        end
        $finish;
    end

endmodule
